// ----- design/xcfd_pkg.sv -----
// shared types and constants for the xor checked frame deframer
package xcfd_pkg;

  localparam int ByteW = 8;

  typedef logic [ByteW-1:0] byte_t;

  // register indexes on the configuration port
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t RegStartMarker = 2'd0;
  localparam reg_idx_t RegCheckSeed   = 2'd1;
  localparam reg_idx_t RegMaxPayload  = 2'd2;

  localparam byte_t StartMarkerRst = 8'd170;
  localparam byte_t CheckSeedRst   = 8'd0;
  localparam byte_t MaxPayloadRst  = 8'd254;

  // frame end status codes
  typedef logic [1:0] status_t;
  localparam status_t StOk   = 2'd0;
  localparam status_t StBad  = 2'd1;
  localparam status_t StZero = 2'd2;
  localparam status_t StLong = 2'd3;

  // result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindReport  = 1'b1;

  typedef struct packed {
    byte_t start_marker;
    byte_t check_seed;
    byte_t max_payload;
  } cfg_t;

  typedef struct packed {
    logic    kind;
    byte_t   data_byte;
    byte_t   byte_index;
    byte_t   command;
    byte_t   payload_length;
    status_t status;
    logic    last;
  } res_t;

endpackage

// ----- design/xcfd_parser.sv -----
// frame parser state and per-byte step logic
module xcfd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  xcfd_pkg::byte_t      rx_byte,
  input  xcfd_pkg::cfg_t       cfg,
  output logic                 res_valid,
  output xcfd_pkg::res_t       res
);

  typedef enum logic [2:0] {
    PH_HUNT      = 3'd0,
    PH_LEN       = 3'd1,
    PH_CMD       = 3'd2,
    PH_PAY       = 3'd3,
    PH_CHECK     = 3'd4,
    PH_LONG_CMD  = 3'd5,
    PH_LONG_SKIP = 3'd6,
    PH_LONG_CHK  = 3'd7
  } phase_t;

  phase_t          phase, phase_next;
  xcfd_pkg::byte_t running_check, running_check_next;
  xcfd_pkg::byte_t bytes_left, bytes_left_next;
  xcfd_pkg::byte_t held_command, held_command_next;
  xcfd_pkg::byte_t held_length, held_length_next;
  xcfd_pkg::byte_t payload_position, payload_position_next;
  xcfd_pkg::byte_t len_m1;

  assign len_m1 = rx_byte - 8'd1;

  always_comb begin
    phase_next            = phase;
    running_check_next    = running_check;
    bytes_left_next       = bytes_left;
    held_command_next     = held_command;
    held_length_next      = held_length;
    payload_position_next = payload_position;
    res_valid             = 1'b0;
    res                   = '0;
    case (phase)
      PH_LEN: begin
        running_check_next = running_check ^ rx_byte;
        if (rx_byte == 8'd0) begin
          phase_next = PH_HUNT;
          res_valid  = 1'b1;
          res.kind   = xcfd_pkg::KindReport;
          res.last   = 1'b1;
          res.status = xcfd_pkg::StZero;
        end else begin
          held_length_next      = len_m1;
          bytes_left_next       = len_m1;
          payload_position_next = 8'd0;
          phase_next = (len_m1 > cfg.max_payload) ? PH_LONG_CMD : PH_CMD;
        end
      end
      PH_CMD, PH_LONG_CMD: begin
        running_check_next = running_check ^ rx_byte;
        held_command_next  = rx_byte;
        if (phase == PH_LONG_CMD) begin
          phase_next = (bytes_left == 8'd0) ? PH_LONG_CHK : PH_LONG_SKIP;
        end else begin
          phase_next = (bytes_left == 8'd0) ? PH_CHECK : PH_PAY;
        end
      end
      PH_PAY: begin
        running_check_next     = running_check ^ rx_byte;
        res_valid              = 1'b1;
        res.kind               = xcfd_pkg::KindPayload;
        res.data_byte          = rx_byte;
        res.byte_index         = payload_position;
        res.command            = held_command;
        res.payload_length     = held_length;
        res.status             = xcfd_pkg::StOk;
        res.last               = 1'b0;
        payload_position_next  = payload_position + 8'd1;
        bytes_left_next        = bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          phase_next = PH_CHECK;
        end
      end
      PH_LONG_SKIP: begin
        running_check_next    = running_check ^ rx_byte;
        payload_position_next = payload_position + 8'd1;
        bytes_left_next       = bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          phase_next = PH_LONG_CHK;
        end
      end
      PH_CHECK: begin
        phase_next         = PH_HUNT;
        res_valid          = 1'b1;
        res.kind           = xcfd_pkg::KindReport;
        res.last           = 1'b1;
        res.command        = held_command;
        res.payload_length = held_length;
        res.status = (rx_byte == running_check) ? xcfd_pkg::StOk : xcfd_pkg::StBad;
      end
      PH_LONG_CHK: begin
        phase_next         = PH_HUNT;
        res_valid          = 1'b1;
        res.kind           = xcfd_pkg::KindReport;
        res.last           = 1'b1;
        res.command        = held_command;
        res.payload_length = held_length;
        res.status         = xcfd_pkg::StLong;
      end
      default: begin
        if (rx_byte == cfg.start_marker) begin
          running_check_next = cfg.check_seed ^ rx_byte;
          phase_next         = PH_LEN;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      running_check    <= 8'd0;
      bytes_left       <= 8'd0;
      held_command     <= 8'd0;
      held_length      <= 8'd0;
      payload_position <= 8'd0;
    end else if (step) begin
      phase            <= phase_next;
      running_check    <= running_check_next;
      bytes_left       <= bytes_left_next;
      held_command     <= held_command_next;
      held_length      <= held_length_next;
      payload_position <= payload_position_next;
    end
  end

endmodule

// ----- design/xor_checked_frame_deframer.sv -----
// top level: input register, frame parser, result register and config registers
// Receive-side frame parser for start/length/command/payload/xor-check frames. It takes one
// byte per cycle on the input channel, but a full result register that is not taken holds
// the next byte in the input register. It gives at most one item per byte: each payload byte
// as it arrives, and one frame end report on the check byte (or at once on a zero length).
// A byte passes through the input register and the parser step into the result register,
// and its result is shown from the result register. Configuration writes are taken in any
// cycle and should be made only while no frame is in progress; writing an index beyond the
// register list has no effect.
module xor_checked_frame_deframer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  xcfd_pkg::byte_t     rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output xcfd_pkg::byte_t     data_byte,
  output xcfd_pkg::byte_t     byte_index,
  output xcfd_pkg::byte_t     command,
  output xcfd_pkg::byte_t     payload_length,
  output xcfd_pkg::status_t   status,
  output logic                last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  xcfd_pkg::reg_idx_t  cfg_index,
  input  xcfd_pkg::byte_t     cfg_data
);

  xcfd_pkg::cfg_t   cfg;
  logic             in_full;
  xcfd_pkg::byte_t  in_byte;
  logic             out_full;
  xcfd_pkg::res_t   out_res;
  logic             advance;
  logic             res_valid;
  xcfd_pkg::res_t   res;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_full || out_ready);
  assign in_ready  = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= xcfd_pkg::StartMarkerRst;
      cfg.check_seed   <= xcfd_pkg::CheckSeedRst;
      cfg.max_payload  <= xcfd_pkg::MaxPayloadRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        xcfd_pkg::RegStartMarker: cfg.start_marker <= cfg_data;
        xcfd_pkg::RegCheckSeed:   cfg.check_seed   <= cfg_data;
        xcfd_pkg::RegMaxPayload:  cfg.max_payload  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  xcfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance && res_valid) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign out_valid      = out_full;
  assign kind           = out_res.kind;
  assign data_byte      = out_res.data_byte;
  assign byte_index     = out_res.byte_index;
  assign command        = out_res.command;
  assign payload_length = out_res.payload_length;
  assign status         = out_res.status;
  assign last           = out_res.last;

endmodule

// ----- design/xcfd_checker.sv -----
// port checker for the deframer, bound to the top level
module xcfd_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic                kind,
  input xcfd_pkg::byte_t     data_byte,
  input xcfd_pkg::byte_t     byte_index,
  input xcfd_pkg::byte_t     command,
  input xcfd_pkg::byte_t     payload_length,
  input xcfd_pkg::status_t   status,
  input logic                last
);

  // no item right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("item shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(status)
      && $stable(last) && $stable(byte_index) && $stable(command))
    else $error("stalled item changed");

  a_report_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> kind == xcfd_pkg::KindReport && data_byte == 8'd0
      && byte_index == 8'd0)
    else $error("frame end report malformed");

  a_payload_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> kind == xcfd_pkg::KindPayload && status == xcfd_pkg::StOk
      && byte_index < payload_length)
    else $error("payload item malformed");

endmodule

bind xor_checked_frame_deframer xcfd_checker u_xcfd_checker (.*);
